// ===== src/tls12_prf_sha256_engine_assert.svh =====
// Assertion macros for the TLS 1.2 PRF engine checker
`ifndef TLS12_PRF_SHA256_ENGINE_ASSERT_SVH
`define TLS12_PRF_SHA256_ENGINE_ASSERT_SVH

// prop holds in the same cycle as trigger
`define TPS_ASSERT_SAME(name, clk, rst_n, trig, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error("tps same-cycle check failed");

// prop holds in the cycle after trigger
`define TPS_ASSERT_NEXT(name, clk, rst_n, trig, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("tps next-cycle check failed");

`endif

// ===== src/tps_pkg.sv =====
// Types, constants and round tables shared by the TLS 1.2 PRF engine
package tps_pkg;

  localparam int KEY_BYTES_MAX_DEF  = 64;
  localparam int SEED_BYTES_MAX_DEF = 128;
  localparam int OUT_BYTES_MAX_DEF  = 256;
  localparam logic [8:0] OUT_LEN_RESET = 9'd48;

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [7:0] PAD_ONE = 8'h80;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_SEED = 1'b1;

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  valid_bytes;
    logic        final_res;
  } out_t;

  // message that follows the pad block in one hash pass
  typedef enum logic [1:0] {
    KIND_SEED,
    KIND_CHAIN_SEED,
    KIND_CHAIN,
    KIND_INNER
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS_INIT,
    ST_FETCH,
    ST_SHIFT,
    ST_COMP_INIT,
    ST_ROUND,
    ST_COMP_ADD,
    ST_PASS_END,
    ST_CHECK,
    ST_EMIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic  accept;
    logic  pass_init;
    logic  fetch;
    logic  shift;
    logic  comp_init;
    logic  round;
    logic  comp_add;
    logic  save_inner;
    logic  save_chain;
    logic  emit;
    logic  finish;
    kind_e kind;
    logic  outer;
  } cmd_t;

  typedef struct packed {
    logic blk_end;
    logic pass_done;
    logic round_last;
    logic emit_last;
    logic last_word;
    logic req_done;
  } sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== src/tls12_prf_sha256_engine.sv =====
// Top level of the TLS 1.2 P_SHA256 expansion engine
// Key and seed bytes: one per cycle, busy stays low while loading.
// Last seed byte: busy for one HMAC A(1), then per 32 output bytes an HMAC(A||seed)
// and, if more bytes follow, an HMAC(A); each 64-byte SHA block is fed a byte at a time
// (fetch through the registered key/seed reads, then shift), then runs 64 rounds and the add.
// Result words leave one per cycle while a digest is emitted, one strobe cycle each; the receiver cannot stall.
// Async active-low reset clears counts, output_length (48) and control; stores are not cleared.
module tls12_prf_sha256_engine import tps_pkg::*; #(
  parameter int KEY_BYTES_MAX  = KEY_BYTES_MAX_DEF,
  parameter int SEED_BYTES_MAX = SEED_BYTES_MAX_DEF,
  parameter int OUT_BYTES_MAX  = OUT_BYTES_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         in_i,
  output logic        result_valid_o,
  output out_t        result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] out_len_q;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {23'd0, out_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= OUT_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      out_len_q <= pwdata[8:0];
    end
  end

  tps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .in_i   (in_i),
    .sts_i  (sts),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  tps_dp #(
    .KEY_BYTES_MAX (KEY_BYTES_MAX),
    .SEED_BYTES_MAX(SEED_BYTES_MAX),
    .OUT_BYTES_MAX (OUT_BYTES_MAX)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_i       (in_i),
    .out_len_i  (out_len_q),
    .sts_o      (sts),
    .res_valid_o(result_valid_o),
    .res_o      (result_o)
  );

endmodule

// ===== src/tps_ctrl.sv =====
// Sequencer for the HMAC passes, output emission and input loading
module tps_ctrl import tps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  in_i,
  input  sts_t sts_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic   outer_q, outer_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_SEED;
      outer_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      outer_q <= outer_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    outer_d = outer_q;
    cmd_o   = '0;
    cmd_o.kind  = kind_q;
    cmd_o.outer = outer_q;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        cmd_o.accept = start_i;
        if (start_i && in_i.operation == OP_SEED && in_i.last) begin
          kind_d  = KIND_SEED;
          outer_d = 1'b0;
          state_d = ST_PASS_INIT;
        end
      end
      ST_PASS_INIT: begin
        cmd_o.pass_init = 1'b1;
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d = sts_i.blk_end ? ST_COMP_INIT : ST_FETCH;
      end
      ST_COMP_INIT: begin
        cmd_o.comp_init = 1'b1;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) state_d = ST_COMP_ADD;
      end
      ST_COMP_ADD: begin
        cmd_o.comp_add = 1'b1;
        state_d = sts_i.pass_done ? ST_PASS_END : ST_FETCH;
      end
      ST_PASS_END: begin
        if (!outer_q) begin
          cmd_o.save_inner = 1'b1;
          outer_d = 1'b1;
          state_d = ST_PASS_INIT;
        end else begin
          case (kind_q)
            KIND_SEED: begin
              cmd_o.save_chain = 1'b1;
              state_d = ST_CHECK;
            end
            KIND_CHAIN_SEED: begin
              state_d = ST_EMIT;
            end
            KIND_CHAIN: begin
              cmd_o.save_chain = 1'b1;
              kind_d  = KIND_CHAIN_SEED;
              outer_d = 1'b0;
              state_d = ST_PASS_INIT;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_CHECK: begin
        if (sts_i.req_done) begin
          state_d = ST_FINISH;
        end else begin
          kind_d  = KIND_CHAIN_SEED;
          outer_d = 1'b0;
          state_d = ST_PASS_INIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_last) begin
          if (sts_i.last_word) begin
            state_d = ST_FINISH;
          end else begin
            kind_d  = KIND_CHAIN;
            outer_d = 1'b0;
            state_d = ST_PASS_INIT;
          end
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/tps_dp.sv =====
// Datapath: key and seed stores, message byte feeder, SHA-256 round unit, output words
module tps_dp import tps_pkg::*; #(
  parameter int KEY_BYTES_MAX  = KEY_BYTES_MAX_DEF,
  parameter int SEED_BYTES_MAX = SEED_BYTES_MAX_DEF,
  parameter int OUT_BYTES_MAX  = OUT_BYTES_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  in_t        in_i,
  input  logic [8:0] out_len_i,
  output sts_t       sts_o,
  output logic       res_valid_o,
  output out_t       res_o
);

  localparam int KAW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int KCW = $clog2(KEY_BYTES_MAX + 1);
  localparam int SAW = (SEED_BYTES_MAX > 1) ? $clog2(SEED_BYTES_MAX) : 1;
  localparam int SCW = $clog2(SEED_BYTES_MAX + 1);
  // pad block + chain + seed + padding
  localparam int PW  = $clog2(SEED_BYTES_MAX + 64 + 32 + 72 + 1);
  localparam int NW  = $clog2(OUT_BYTES_MAX + 1);

  // input loading
  logic [7:0]     key_mem [KEY_BYTES_MAX];
  logic [7:0]     seed_mem [SEED_BYTES_MAX];
  logic [KCW-1:0] key_cnt_q, key_base;
  logic           key_closed_q;
  logic [SCW-1:0] seed_cnt_q;
  logic           key_we, seed_we;
  logic [7:0]     key_rd_q, seed_rd_q;

  logic [PW-1:0]  p_q;
  logic [PW-1:0]  seed_addr;
  kind_e          kind;

  assign key_base = key_closed_q ? '0 : key_cnt_q;
  assign key_we   = cmd_i.accept && in_i.operation == OP_KEY &&
                    key_base < KCW'(KEY_BYTES_MAX);
  assign seed_we  = cmd_i.accept && in_i.operation == OP_SEED &&
                    seed_cnt_q < SCW'(SEED_BYTES_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_cnt_q    <= '0;
      key_closed_q <= 1'b0;
      seed_cnt_q   <= '0;
    end else begin
      if (cmd_i.accept && in_i.operation == OP_KEY) begin
        key_cnt_q    <= key_we ? key_base + KCW'(1) : key_base;
        key_closed_q <= in_i.last;
      end
      if (seed_we) seed_cnt_q <= seed_cnt_q + SCW'(1);
      else if (cmd_i.finish) seed_cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_base[KAW-1:0]] <= in_i.data_byte;
    if (cmd_i.fetch) key_rd_q <= key_mem[p_q[KAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (seed_we) seed_mem[seed_cnt_q[SAW-1:0]] <= in_i.data_byte;
    if (cmd_i.fetch) seed_rd_q <= seed_mem[seed_addr[SAW-1:0]];
  end

  // message layout of the current pass
  logic [PW-1:0]  mlen, len_l, padded, m_idx, len_j;
  logic [PW+2:0]  bit_len;
  logic [63:0]    len64;
  logic [4:0]     cb_idx;
  logic [255:0]   chain_q, inner_q, digest;
  logic [7:0]     chain_byte, inner_byte, pad_byte, msg_byte, feed_byte;

  assign kind = cmd_i.outer ? KIND_INNER : cmd_i.kind;

  always_comb begin
    case (kind)
      KIND_SEED:       mlen = PW'(seed_cnt_q);
      KIND_CHAIN_SEED: mlen = PW'(seed_cnt_q) + PW'(32);
      default:         mlen = PW'(32);
    endcase
  end

  assign len_l     = mlen + PW'(64);
  assign padded    = ((len_l + PW'(72)) >> 6) << 6;
  assign m_idx     = p_q - PW'(64);
  assign seed_addr = (kind == KIND_SEED) ? p_q - PW'(64) : p_q - PW'(96);
  assign bit_len   = {len_l, 3'b000};
  assign len64     = 64'(bit_len);
  assign len_j     = padded - PW'(1) - p_q;
  assign cb_idx    = ~m_idx[4:0];
  assign chain_byte = chain_q[{cb_idx, 3'b000} +: 8];
  assign inner_byte = inner_q[{cb_idx, 3'b000} +: 8];
  assign pad_byte   = ((p_q < PW'(key_cnt_q)) ? key_rd_q : 8'h00) ^
                      (cmd_i.outer ? OPAD : IPAD);

  always_comb begin
    case (kind)
      KIND_SEED:       msg_byte = seed_rd_q;
      KIND_CHAIN_SEED: msg_byte = (m_idx < PW'(32)) ? chain_byte : seed_rd_q;
      KIND_CHAIN:      msg_byte = chain_byte;
      default:         msg_byte = inner_byte;
    endcase
  end

  always_comb begin
    if (p_q < PW'(64))                    feed_byte = pad_byte;
    else if (p_q < len_l)                 feed_byte = msg_byte;
    else if (p_q == len_l)                feed_byte = PAD_ONE;
    else if (p_q >= padded - PW'(8))      feed_byte = len64[{len_j[2:0], 3'b000} +: 8];
    else                                  feed_byte = 8'h00;
  end

  // SHA-256 round unit
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [8];
  logic [511:0] blk_q;
  logic [5:0]   rnd_q;
  logic [31:0]  w_t, w_new, t1, t2;

  assign w_t   = blk_q[511:480];
  assign w_new = ssig1(blk_q[63:32]) + blk_q[223:192] + ssig0(blk_q[479:448]) + w_t;
  assign t1    = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
                 K_ROUND[rnd_q] + w_t;
  assign t2    = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign digest = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_init) begin
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
      p_q <= '0;
    end
    if (cmd_i.shift) begin
      blk_q <= {blk_q[503:0], feed_byte};
      p_q   <= p_q + PW'(1);
    end
    if (cmd_i.comp_init) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      rnd_q <= '0;
    end
    if (cmd_i.round) begin
      blk_q  <= {blk_q[479:0], w_new};
      rnd_q  <= rnd_q + 6'd1;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.comp_add) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
    if (cmd_i.save_inner) inner_q <= digest;
    if (cmd_i.save_chain) chain_q <= digest;
  end

  // output words
  logic [NW-1:0] need, emitted_q, remaining;
  logic [1:0]    widx_q;
  logic [3:0]    valid;
  logic [63:0]   word_raw, word_mask;

  always_comb begin
    if (int'(out_len_i) > OUT_BYTES_MAX) need = NW'(OUT_BYTES_MAX);
    else                                 need = NW'(out_len_i);
  end

  assign remaining = need - emitted_q;
  assign valid     = (remaining > NW'(8)) ? 4'd8 : remaining[3:0];
  assign word_raw  = digest[{~widx_q, 6'b000000} +: 64];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      word_mask[63-8*j -: 8] = (4'(j) < valid) ? word_raw[63-8*j -: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emitted_q   <= '0;
      widx_q      <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.emit;
      if (cmd_i.pass_init) widx_q <= '0;
      else if (cmd_i.emit) widx_q <= widx_q + 2'd1;
      if (cmd_i.finish) emitted_q <= '0;
      else if (cmd_i.emit) emitted_q <= emitted_q + NW'(valid);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_o.word        <= word_mask;
      res_o.valid_bytes <= valid;
      res_o.final_res   <= remaining <= NW'(8);
    end
  end

  assign sts_o.blk_end    = p_q[5:0] == 6'd63;
  assign sts_o.pass_done  = p_q == padded;
  assign sts_o.round_last = rnd_q == 6'd63;
  assign sts_o.last_word  = remaining <= NW'(8);
  assign sts_o.emit_last  = (remaining <= NW'(8)) || widx_q == 2'd3;
  assign sts_o.req_done   = emitted_q >= need;

endmodule

// ===== src/tps_checker.sv =====
// Port-level checks for the TLS 1.2 PRF engine, bound to the top level
`include "tls12_prf_sha256_engine_assert.svh"

module tps_checker import tps_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic result_valid_o,
  input out_t result_o
);

  // results only appear while a request is being worked
  `TPS_ASSERT_SAME(a_res_busy, clk_i, rst_ni, result_valid_o, busy)
  `TPS_ASSERT_SAME(a_bytes_range, clk_i, rst_ni, result_valid_o, result_o.valid_bytes != 4'd0 && result_o.valid_bytes <= 4'd8)
  `TPS_ASSERT_SAME(a_full_word, clk_i, rst_ni, result_valid_o && !result_o.final_res, result_o.valid_bytes == 4'd8)
  // engine returns to idle right after the final transaction
  `TPS_ASSERT_NEXT(a_final_idle, clk_i, rst_ni, result_valid_o && result_o.final_res, !busy && !result_valid_o)

endmodule

bind tls12_prf_sha256_engine tps_checker u_tps_checker (.*);
